>>> hw/rtl/bvdf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bvdf_pkg: shared types and helpers for the body velocity update
// Fixed-point widths, pipeline item types and saturating helpers.
// ----------------------------------------------------------------------------
package bvdf_pkg;

  localparam int SPD_W      = 24;   // signed Q16.8 speed
  localparam int FRAC_BITS  = 8;
  localparam int REG_W      = 16;
  localparam int SUM_W      = 2 * SPD_W;
  localparam int ROOT_W     = SPD_W;
  localparam int REM_W      = ROOT_W + 3;
  localparam int STEP_SHIFT = 16 - FRAC_BITS;   // gravity and drag steps
  localparam int FV_SHIFT   = 17 - FRAC_BITS;   // friction with mean
  localparam int SQRT_CELLS = ROOT_W;
  localparam int DIV_CELLS  = SPD_W;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_GRAVITY    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AIR_DRAG   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_TIME = 2'd2;

  localparam logic [REG_W-1:0] GRAVITY_RST    = 16'd2000;
  localparam logic [REG_W-1:0] AIR_DRAG_RST   = 16'd50;
  localparam logic [REG_W-1:0] FRAME_TIME_RST = 16'd1092;

  localparam logic signed [SPD_W-1:0] SPD_MAX = 24'sh7FFFFF;
  localparam logic signed [SPD_W-1:0] SPD_MIN = 24'sh800000;

  // one input transaction
  typedef struct packed {
    logic signed [SPD_W-1:0] speed_x;
    logic signed [SPD_W-1:0] speed_y;
    logic                    movable;
    logic [REG_W-1:0]        own_friction;
    logic                    down_present;
    logic signed [SPD_W-1:0] down_speed_x;
    logic [REG_W-1:0]        down_friction;
    logic                    down_movable;
    logic                    right_present;
    logic signed [SPD_W-1:0] right_speed_y;
    logic [REG_W-1:0]        right_friction;
    logic                    right_movable;
  } in_t;

  // body state carried down the pipeline
  typedef struct packed {
    logic signed [SPD_W-1:0] vx;
    logic signed [SPD_W-1:0] vy;
    logic signed [SPD_W-1:0] dvx;
    logic signed [SPD_W-1:0] rvy;
    logic                    mov;
    logic                    dp;
    logic                    dm;
    logic                    rp;
    logic                    rm;
    logic [SPD_W-1:0]        fvd;
    logic [SPD_W-1:0]        fvr;
    logic                    zero;
  } item_t;

  // one divider lane: partial remainder and dividend / quotient shifter
  typedef struct packed {
    logic [SPD_W-1:0] rem;
    logic [SPD_W-1:0] low;
  } div_lane_t;

  // one result transaction
  typedef struct packed {
    logic signed [SPD_W-1:0] new_speed_x;
    logic signed [SPD_W-1:0] new_speed_y;
    logic signed [SPD_W-1:0] new_down_speed_x;
    logic signed [SPD_W-1:0] new_right_speed_y;
  } res_t;

  // magnitude of a signed speed; -2^23 maps to 2^23
  function automatic logic [SPD_W-1:0] mag24(input logic signed [SPD_W-1:0] v);
    logic [SPD_W-1:0] u;
    u = v;
    return v[SPD_W-1] ? (~u + 1'b1) : u;
  endfunction

  // clamp a two-bit-wider value to the speed range
  function automatic logic signed [SPD_W-1:0] sat24(input logic signed [SPD_W+1:0] v);
    logic signed [SPD_W+1:0] hi;
    logic signed [SPD_W+1:0] lo;
    hi = {{2{SPD_MAX[SPD_W-1]}}, SPD_MAX};
    lo = {{2{SPD_MIN[SPD_W-1]}}, SPD_MIN};
    if (v > hi) return SPD_MAX;
    if (v < lo) return SPD_MIN;
    return v[SPD_W-1:0];
  endfunction

  // move self toward other by fv; snap to other when within fv
  function automatic logic signed [SPD_W-1:0] toward(input logic signed [SPD_W-1:0] self,
                                                     input logic signed [SPD_W-1:0] other,
                                                     input logic [SPD_W-1:0] fv);
    logic signed [SPD_W:0]   rel;
    logic [SPD_W:0]          mag;
    logic signed [SPD_W+1:0] step;
    logic signed [SPD_W+1:0] t;
    rel  = {self[SPD_W-1], self} - {other[SPD_W-1], other};
    mag  = rel[SPD_W] ? (~rel + 1'b1) : rel;
    step = {2'b00, fv};
    t    = rel[SPD_W] ? ({{2{self[SPD_W-1]}}, self} + step)
                      : ({{2{self[SPD_W-1]}}, self} - step);
    if (mag > {1'b0, fv}) return sat24(t);
    return other;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/bvdf_sqrt_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bvdf_sqrt_cell: one root bit of the speed magnitude
// Takes two radicand bits, resolves one root bit and passes the body on.
// ----------------------------------------------------------------------------
module bvdf_sqrt_cell
  import bvdf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              adv,
  input  wire logic              in_vld,
  input  wire item_t             in_item,
  input  wire logic [SUM_W-1:0]  in_n,
  input  wire logic [REM_W-1:0]  in_rem,
  input  wire logic [ROOT_W-1:0] in_root,
  output logic                   out_vld,
  output item_t                  out_item,
  output logic [SUM_W-1:0]       out_n,
  output logic [REM_W-1:0]       out_rem,
  output logic [ROOT_W-1:0]      out_root
);

  logic              vld_r;
  item_t             item_r;
  logic [SUM_W-1:0]  n_r;
  logic [REM_W-1:0]  rem_r;
  logic [ROOT_W-1:0] root_r;

  logic [REM_W-1:0]  rem_sh;
  logic [REM_W-1:0]  trial;
  logic              ge;

  // trial subtract of (4*root + 1)
  assign rem_sh = {in_rem[REM_W-3:0], in_n[SUM_W-1 -: 2]};
  assign trial  = {1'b0, in_root, 2'b01};
  assign ge     = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      item_r <= in_item;
      n_r    <= {in_n[SUM_W-3:0], 2'b00};
      rem_r  <= ge ? (rem_sh - trial) : rem_sh;
      root_r <= {in_root[ROOT_W-2:0], ge};
    end
  end

  assign out_vld  = vld_r;
  assign out_item = item_r;
  assign out_n    = n_r;
  assign out_rem  = rem_r;
  assign out_root = root_r;

endmodule
`default_nettype wire

>>> hw/rtl/bvdf_div_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bvdf_div_cell: one quotient bit of the drag share, x and y lanes
// Restoring divide step by the speed magnitude on both lanes.
// ----------------------------------------------------------------------------
module bvdf_div_cell
  import bvdf_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             adv,
  input  wire logic             in_vld,
  input  wire item_t            in_item,
  input  wire logic [SPD_W-1:0] in_m,
  input  wire div_lane_t        in_lx,
  input  wire div_lane_t        in_ly,
  output logic                  out_vld,
  output item_t                 out_item,
  output logic [SPD_W-1:0]      out_m,
  output div_lane_t             out_lx,
  output div_lane_t             out_ly
);

  logic             vld_r;
  item_t            item_r;
  logic [SPD_W-1:0] m_r;
  div_lane_t        lx_r;
  div_lane_t        ly_r;

  // single restoring step on one lane
  function automatic div_lane_t div_step(input div_lane_t l, input logic [SPD_W-1:0] m);
    logic [SPD_W:0] sh;
    logic [SPD_W:0] df;
    logic           ge;
    div_lane_t      r;
    sh    = {l.rem, l.low[SPD_W-1]};
    df    = sh - {1'b0, m};
    ge    = (sh >= {1'b0, m});
    r.rem = ge ? df[SPD_W-1:0] : sh[SPD_W-1:0];
    r.low = {l.low[SPD_W-2:0], ge};
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      item_r <= in_item;
      m_r    <= in_m;
      lx_r   <= div_step(in_lx, in_m);
      ly_r   <= div_step(in_ly, in_m);
    end
  end

  assign out_vld  = vld_r;
  assign out_item = item_r;
  assign out_m    = m_r;
  assign out_lx   = lx_r;
  assign out_ly   = ly_r;

endmodule
`default_nettype wire

>>> hw/rtl/bvdf_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bvdf_front: gravity, friction amounts and squared speed magnitude
// Three stages: gravity and friction products, squares, sum and drag test.
// ----------------------------------------------------------------------------
module bvdf_front
  import bvdf_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             adv,
  input  wire logic             in_vld,
  input  wire in_t              in_data,
  input  wire logic [REG_W-1:0] gravity,
  input  wire logic [REG_W-1:0] frame_time,
  input  wire logic [SPD_W-1:0] drag_step,
  output logic                  out_vld,
  output item_t                 out_item,
  output logic [SUM_W-1:0]      out_sum
);

  logic [2*REG_W-1:0]   g_prod;
  logic [SPD_W-1:0]     g_step;
  logic [REG_W:0]       fd_sum;
  logic [REG_W:0]       fr_sum;
  logic [2*REG_W:0]     fd_prod;
  logic [2*REG_W:0]     fr_prod;
  logic signed [SPD_W-1:0] vy_g;
  item_t                s1_nxt;
  item_t                item3_nxt;
  logic [SUM_W-1:0]     sum_nxt;

  logic                 v1_r, v2_r, v3_r;
  item_t                item1_r, item2_r, item3_r;
  logic [SUM_W-2:0]     ax2_r, ay2_r;
  logic [SUM_W-1:0]     sum_r;
  logic [SUM_W-1:0]     dd_r;

  // stage 1: gravity step and per-contact friction amounts
  assign g_prod  = gravity * frame_time;
  assign g_step  = SPD_W'(g_prod >> STEP_SHIFT);
  assign fd_sum  = {1'b0, in_data.own_friction} + {1'b0, in_data.down_friction};
  assign fr_sum  = {1'b0, in_data.own_friction} + {1'b0, in_data.right_friction};
  assign fd_prod = fd_sum * frame_time;
  assign fr_prod = fr_sum * frame_time;
  assign vy_g    = sat24({{2{in_data.speed_y[SPD_W-1]}}, in_data.speed_y}
                         + {2'b00, g_step});

  always_comb begin
    s1_nxt.vx   = in_data.speed_x;
    s1_nxt.vy   = in_data.movable ? vy_g : in_data.speed_y;
    s1_nxt.dvx  = in_data.down_speed_x;
    s1_nxt.rvy  = in_data.right_speed_y;
    s1_nxt.mov  = in_data.movable;
    s1_nxt.dp   = in_data.down_present;
    s1_nxt.dm   = in_data.down_movable;
    s1_nxt.rp   = in_data.right_present;
    s1_nxt.rm   = in_data.right_movable;
    s1_nxt.fvd  = SPD_W'(fd_prod >> FV_SHIFT);
    s1_nxt.fvr  = SPD_W'(fr_prod >> FV_SHIFT);
    s1_nxt.zero = 1'b0;
  end

  // stage 3 inputs: sum of squares and the full-stop test
  assign sum_nxt = {1'b0, ax2_r} + {1'b0, ay2_r};

  always_comb begin
    item3_nxt      = item2_r;
    item3_nxt.zero = (sum_nxt < dd_r);
  end

  // squared drag step is a register fed from the drag step input
  always_ff @(posedge clk) begin
    dd_r <= drag_step * drag_step;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      item1_r <= s1_nxt;
      // stage 2: squares of the magnitudes
      item2_r <= item1_r;
      ax2_r   <= mag24(item1_r.vx) * mag24(item1_r.vx);
      ay2_r   <= mag24(item1_r.vy) * mag24(item1_r.vy);
      // stage 3: sum and the full-stop test
      item3_r <= item3_nxt;
      sum_r   <= sum_nxt;
    end
  end

  assign out_vld  = v3_r;
  assign out_item = item3_r;
  assign out_sum  = sum_r;

endmodule
`default_nettype wire

>>> hw/rtl/bvdf_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bvdf_back: drag application and contact friction
// Registered drag stage, then friction with the lower and right contacts.
// ----------------------------------------------------------------------------
module bvdf_back
  import bvdf_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             adv,
  input  wire logic             in_vld,
  input  wire item_t            in_item,
  input  wire logic [SPD_W-1:0] in_m,
  input  wire logic [SPD_W-1:0] in_qx,
  input  wire logic [SPD_W-1:0] in_qy,
  output logic                  out_vld,
  output res_t                  out_res
);

  logic             vld_r;
  item_t            item_r;
  item_t            drag_nxt;
  logic [SPD_W-1:0] ux, uy;

  // drag share moves each component toward zero; never overshoots
  always_comb begin
    ux       = in_item.vx;
    uy       = in_item.vy;
    drag_nxt = in_item;
    if (in_item.mov) begin
      if (in_item.zero) begin
        drag_nxt.vx = '0;
        drag_nxt.vy = '0;
      end else if (in_m != '0) begin
        drag_nxt.vx = in_item.vx[SPD_W-1] ? (ux + in_qx) : (ux - in_qx);
        drag_nxt.vy = in_item.vy[SPD_W-1] ? (uy + in_qy) : (uy - in_qy);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      item_r <= drag_nxt;
    end
  end

  // friction: down contact acts on x, right contact on y
  always_comb begin
    out_res.new_speed_x       = item_r.vx;
    out_res.new_speed_y       = item_r.vy;
    out_res.new_down_speed_x  = item_r.dvx;
    out_res.new_right_speed_y = item_r.rvy;
    if (item_r.dp) begin
      if (item_r.mov) out_res.new_speed_x = toward(item_r.vx, item_r.dvx, item_r.fvd);
      if (item_r.dm)  out_res.new_down_speed_x = toward(item_r.dvx, item_r.vx, item_r.fvd);
    end
    if (item_r.rp) begin
      if (item_r.mov) out_res.new_speed_y = toward(item_r.vy, item_r.rvy, item_r.fvr);
      if (item_r.rm)  out_res.new_right_speed_y = toward(item_r.rvy, item_r.vy, item_r.fvr);
    end
  end

  assign out_vld = vld_r;

  // a fixed body leaves the drag stage untouched
  a_fixed_hold: assert property (@(posedge clk) disable iff (!rst_n)
    adv && in_vld && !in_item.mov |=> item_r.vx == $past(in_item.vx)
                                   && item_r.vy == $past(in_item.vy))
    else $error("fixed body speed changed by drag");

  // a full stop clears both components
  a_full_stop: assert property (@(posedge clk) disable iff (!rst_n)
    adv && in_vld && in_item.mov && in_item.zero |=> item_r.vx == '0 && item_r.vy == '0)
    else $error("full stop left a nonzero speed");

  // a drag share never exceeds the component magnitude
  a_share: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld && in_item.mov && !in_item.zero && in_m != '0
      |-> in_qx <= mag24(in_item.vx) && in_qy <= mag24(in_item.vy))
    else $error("drag share larger than speed");

endmodule
`default_nettype wire

>>> hw/rtl/body_velocity_drag_and_contact_friction.sv
`default_nettype none
// ----------------------------------------------------------------------------
// body_velocity_drag_and_contact_friction: per-body velocity update
// Gravity, air drag and contact friction over a chain of root and divide cells.
// ----------------------------------------------------------------------------
// Structure: 3 front stages, 24 root cells, 1 product stage, 24 divide cells,
//   1 drag stage and an output register between input transaction and result.
// Throughput: one transaction per cycle; the whole cell chain advances together
//   and only holds while a result waits at the output.
// Reset: synchronous active-low rst_n clears all valid bits and loads
//   gravity 2000, air drag 50 and frame time 1092.
module body_velocity_drag_and_contact_friction
  import bvdf_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [REG_W-1:0]     cfg_wdata,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic signed [SPD_W-1:0] in_speed_x,
  input  wire logic signed [SPD_W-1:0] in_speed_y,
  input  wire logic                 in_movable,
  input  wire logic [REG_W-1:0]     in_own_friction,
  input  wire logic                 in_down_present,
  input  wire logic signed [SPD_W-1:0] in_down_speed_x,
  input  wire logic [REG_W-1:0]     in_down_friction,
  input  wire logic                 in_down_movable,
  input  wire logic                 in_right_present,
  input  wire logic signed [SPD_W-1:0] in_right_speed_y,
  input  wire logic [REG_W-1:0]     in_right_friction,
  input  wire logic                 in_right_movable,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic signed [SPD_W-1:0]   out_new_speed_x,
  output logic signed [SPD_W-1:0]   out_new_speed_y,
  output logic signed [SPD_W-1:0]   out_new_down_speed_x,
  output logic signed [SPD_W-1:0]   out_new_right_speed_y
);

  logic [REG_W-1:0]  gravity_r, air_drag_r, frame_time_r;
  logic [SPD_W-1:0]  drag_step_r;
  logic [2*REG_W-1:0] drag_prod;
  logic              adv;
  in_t               in_data;

  logic              fr_vld;
  item_t             fr_item;
  logic [SUM_W-1:0]  fr_sum;

  logic              sq_vld  [0:SQRT_CELLS];
  item_t             sq_item [0:SQRT_CELLS];
  logic [SUM_W-1:0]  sq_n    [0:SQRT_CELLS];
  logic [REM_W-1:0]  sq_rem  [0:SQRT_CELLS];
  logic [ROOT_W-1:0] sq_root [0:SQRT_CELLS];

  logic              dv_vld  [0:DIV_CELLS];
  item_t             dv_item [0:DIV_CELLS];
  logic [SPD_W-1:0]  dv_m    [0:DIV_CELLS];
  div_lane_t         dv_lx   [0:DIV_CELLS];
  div_lane_t         dv_ly   [0:DIV_CELLS];

  logic              pr_vld_r;
  item_t             pr_item_r;
  logic [SPD_W-1:0]  pr_m_r;
  logic [SUM_W-1:0]  pr_x_r, pr_y_r;

  logic              bk_vld;
  res_t              bk_res;
  logic              out_valid_r;
  res_t              out_res_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gravity_r    <= GRAVITY_RST;
      air_drag_r   <= AIR_DRAG_RST;
      frame_time_r <= FRAME_TIME_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GRAVITY:    gravity_r    <= cfg_wdata;
        REG_AIR_DRAG:   air_drag_r   <= cfg_wdata;
        REG_FRAME_TIME: frame_time_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // drag step is first needed two stages in, so it may be a registered copy
  assign drag_prod = air_drag_r * frame_time_r;
  always_ff @(posedge clk) begin
    drag_step_r <= SPD_W'(drag_prod >> STEP_SHIFT);
  end

  // whole chain moves unless a result is held at the output
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  assign in_data.speed_x        = in_speed_x;
  assign in_data.speed_y        = in_speed_y;
  assign in_data.movable        = in_movable;
  assign in_data.own_friction   = in_own_friction;
  assign in_data.down_present   = in_down_present;
  assign in_data.down_speed_x   = in_down_speed_x;
  assign in_data.down_friction  = in_down_friction;
  assign in_data.down_movable   = in_down_movable;
  assign in_data.right_present  = in_right_present;
  assign in_data.right_speed_y  = in_right_speed_y;
  assign in_data.right_friction = in_right_friction;
  assign in_data.right_movable  = in_right_movable;

  bvdf_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .in_vld     (in_valid),
    .in_data    (in_data),
    .gravity    (gravity_r),
    .frame_time (frame_time_r),
    .drag_step  (drag_step_r),
    .out_vld    (fr_vld),
    .out_item   (fr_item),
    .out_sum    (fr_sum)
  );

  // root cell chain
  assign sq_vld[0]  = fr_vld;
  assign sq_item[0] = fr_item;
  assign sq_n[0]    = fr_sum;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;

  for (genvar i = 0; i < SQRT_CELLS; i++) begin : g_sqrt
    bvdf_sqrt_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .in_vld   (sq_vld[i]),
      .in_item  (sq_item[i]),
      .in_n     (sq_n[i]),
      .in_rem   (sq_rem[i]),
      .in_root  (sq_root[i]),
      .out_vld  (sq_vld[i+1]),
      .out_item (sq_item[i+1]),
      .out_n    (sq_n[i+1]),
      .out_rem  (sq_rem[i+1]),
      .out_root (sq_root[i+1])
    );
  end

  // dividends: drag step times each component magnitude
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pr_vld_r <= 1'b0;
    end else if (adv) begin
      pr_vld_r <= sq_vld[SQRT_CELLS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pr_item_r <= sq_item[SQRT_CELLS];
      pr_m_r    <= sq_root[SQRT_CELLS];
      pr_x_r    <= drag_step_r * mag24(sq_item[SQRT_CELLS].vx);
      pr_y_r    <= drag_step_r * mag24(sq_item[SQRT_CELLS].vy);
    end
  end

  // divide cell chain; quotient fits the low half, so the high half preloads
  assign dv_vld[0]    = pr_vld_r;
  assign dv_item[0]   = pr_item_r;
  assign dv_m[0]      = pr_m_r;
  assign dv_lx[0].rem = pr_x_r[SUM_W-1:SPD_W];
  assign dv_lx[0].low = pr_x_r[SPD_W-1:0];
  assign dv_ly[0].rem = pr_y_r[SUM_W-1:SPD_W];
  assign dv_ly[0].low = pr_y_r[SPD_W-1:0];

  for (genvar j = 0; j < DIV_CELLS; j++) begin : g_div
    bvdf_div_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .in_vld   (dv_vld[j]),
      .in_item  (dv_item[j]),
      .in_m     (dv_m[j]),
      .in_lx    (dv_lx[j]),
      .in_ly    (dv_ly[j]),
      .out_vld  (dv_vld[j+1]),
      .out_item (dv_item[j+1]),
      .out_m    (dv_m[j+1]),
      .out_lx   (dv_lx[j+1]),
      .out_ly   (dv_ly[j+1])
    );
  end

  bvdf_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_vld  (dv_vld[DIV_CELLS]),
    .in_item (dv_item[DIV_CELLS]),
    .in_m    (dv_m[DIV_CELLS]),
    .in_qx   (dv_lx[DIV_CELLS].low),
    .in_qy   (dv_ly[DIV_CELLS].low),
    .out_vld (bk_vld),
    .out_res (bk_res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= bk_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res_r <= bk_res;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_new_speed_x       = out_res_r.new_speed_x;
  assign out_new_speed_y       = out_res_r.new_speed_y;
  assign out_new_down_speed_x  = out_res_r.new_down_speed_x;
  assign out_new_right_speed_y = out_res_r.new_right_speed_y;

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r)
    else $error("result valid right after reset");

  // a finished transaction reaches the output when the chain moves
  a_load_out: assert property (@(posedge clk) disable iff (!rst_n)
    adv && bk_vld |=> out_valid_r)
    else $error("finished transaction lost before output");

  // a held chain keeps its contents
  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(bk_vld) && $stable(pr_vld_r) && $stable(fr_vld))
    else $error("pipeline moved while output held");

endmodule
`default_nettype wire
